/* hdl/life_generation_rows_defines.svh */
// assertion macros for the life generation row engine
// no dependencies; included by files that carry assertions
`ifndef LIFE_GENERATION_ROWS_DEFINES_SVH
`define LIFE_GENERATION_ROWS_DEFINES_SVH

`ifndef SYNTHESIS

`define LGR_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("lgr assertion failed");

`define LGR_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("lgr assertion failed");

`else

`define LGR_ASSERT_IMPLIES(label, clk, rst, cond, prop)

`define LGR_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

/* hdl/lgr_pkg.sv */
// shared types, constants and the width mask function for the life row engine
// no dependencies
package lgr_pkg;

  localparam int ROW_W      = 64;
  localparam int MAX_WIDTH  = 64;
  localparam int WIDTH_W    = 7;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int REG_IDX_W  = PADDR_W - 2;

  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = WIDTH_W'(64);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW_WIDTH = REG_IDX_W'(0)
  } lgr_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_cells;
    logic             last_row;
  } lgr_row_t;

  typedef struct packed {
    logic [ROW_W-1:0] next_row;
    logic             last_out;
  } lgr_gen_t;

  // masked bits that one cell shows its neighbors
  typedef struct packed {
    logic upper;
    logic middle;
    logic fresh;
  } lgr_nbr_t;

  typedef struct packed {
    logic load;
    logic have_middle;
    logic last;
  } lgr_ctrl_t;

  typedef struct packed {
    logic first;
    logic second;
  } lgr_push_t;

  function automatic logic [ROW_W-1:0] width_mask(input logic [WIDTH_W-1:0] width);
    logic [WIDTH_W-1:0] w_eff;
    logic [ROW_W-1:0]   m;
    w_eff = (width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width;
    for (int k = 0; k < ROW_W; k++) begin
      m[k] = (k < int'(w_eff));
    end
    return m;
  endfunction

endpackage

/* hdl/life_generation_rows.sv */
// top level of the life generation row engine: config register, cell row, result queue
// depends on lgr_pkg, lgr_cell, lgr_out_fifo and life_generation_rows_defines.svh
//
//   channel   handshake              beat
//   rows in   row_valid/row_ready    row_beat (row_cells, last_row)
//   gens out  gen_valid/gen_ready    gen_beat (next_row, last_out)
//   config    psel/penable/pwrite    paddr, pwdata, prdata (row_width at 0)
//
// one row a cycle while row_ready is high; a row's results land in the queue at the
// edge that takes it; a last row also yields the beat flagged last_out
// row_ready is high while the 4-deep result queue has room for two beats
// synchronous reset clears the stored rows, queue and row_width (back to 64)
`include "life_generation_rows_defines.svh"

module life_generation_rows (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          row_valid,
  output logic                          row_ready,
  input  lgr_pkg::lgr_row_t             row_beat,
  output logic                          gen_valid,
  input  logic                          gen_ready,
  output lgr_pkg::lgr_gen_t             gen_beat,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lgr_pkg::PADDR_W-1:0]   paddr,
  input  logic [lgr_pkg::PDATA_W-1:0]   pwdata,
  output logic [lgr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [lgr_pkg::WIDTH_W-1:0] row_width;
  logic                        have_middle, have_middle_next;
  logic [lgr_pkg::ROW_W-1:0]   row_mask;
  logic [lgr_pkg::ROW_W-1:0]   mid_bits, last_bits;
  logic                        acc;
  logic                        room_two;
  lgr_pkg::lgr_reg_t           reg_idx;
  lgr_pkg::lgr_ctrl_t          ctrl;
  lgr_pkg::lgr_push_t          push;
  lgr_pkg::lgr_gen_t           first_beat, second_beat;
  lgr_pkg::lgr_nbr_t           nbr [lgr_pkg::MAX_WIDTH];

  assign pready  = 1'b1;
  assign reg_idx = lgr_pkg::lgr_reg_t'(paddr[lgr_pkg::PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= lgr_pkg::ROW_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        lgr_pkg::REG_ROW_WIDTH: begin
          row_width <= pwdata[lgr_pkg::WIDTH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lgr_pkg::REG_ROW_WIDTH: prdata = lgr_pkg::PDATA_W'(row_width);
      default:                prdata = '0;
    endcase
  end

  assign row_mask  = lgr_pkg::width_mask(row_width);
  assign row_ready = room_two;
  assign acc       = row_valid & row_ready;
  assign ctrl      = '{load: acc, have_middle: have_middle, last: row_beat.last_row};

  always_comb begin
    have_middle_next = have_middle;
    if (acc) begin
      have_middle_next = !row_beat.last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_middle <= 1'b0;
    end else begin
      have_middle <= have_middle_next;
    end
  end

  for (genvar k = 0; k < lgr_pkg::MAX_WIDTH; k++) begin : g_cell
    lgr_pkg::lgr_nbr_t left, right;
    if (k == 0) begin : g_lo
      assign left = '0;
    end else begin : g_lo_n
      assign left = nbr[k-1];
    end
    if (k == lgr_pkg::MAX_WIDTH - 1) begin : g_hi
      assign right = '0;
    end else begin : g_hi_n
      assign right = nbr[k+1];
    end
    lgr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .mask     (row_mask[k]),
      .fresh    (row_beat.row_cells[k]),
      .left     (left),
      .right    (right),
      .self_nbr (nbr[k]),
      .gen_mid  (mid_bits[k]),
      .gen_last (last_bits[k])
    );
  end

  if (lgr_pkg::MAX_WIDTH < lgr_pkg::ROW_W) begin : g_pad
    assign mid_bits[lgr_pkg::ROW_W-1:lgr_pkg::MAX_WIDTH]  = '0;
    assign last_bits[lgr_pkg::ROW_W-1:lgr_pkg::MAX_WIDTH] = '0;
  end

  assign push        = '{first: acc & have_middle, second: acc & row_beat.last_row};
  assign first_beat  = '{next_row: mid_bits, last_out: 1'b0};
  assign second_beat = '{next_row: last_bits, last_out: 1'b1};

  lgr_out_fifo u_out_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .first_beat  (first_beat),
    .second_beat (second_beat),
    .room_two    (room_two),
    .gen_valid   (gen_valid),
    .gen_ready   (gen_ready),
    .gen_beat    (gen_beat)
  );

  `LGR_ASSERT_NEXT(a_last_ends_grid, clk, rst, acc && row_beat.last_row, !have_middle)
  `LGR_ASSERT_NEXT(a_first_row_held, clk, rst, acc && !have_middle && !row_beat.last_row, have_middle)
  `LGR_ASSERT_NEXT(a_result_queued, clk, rst, acc && (have_middle || row_beat.last_row), gen_valid)
  `LGR_ASSERT_IMPLIES(a_dead_beyond_width, clk, rst, gen_valid, (gen_beat.next_row & ~row_mask) == '0)

endmodule

/* hdl/lgr_cell.sv */
// one column cell: holds the upper and middle bit of its column, counts neighbors
// depends on lgr_pkg
module lgr_cell (
  input  logic              clk,
  input  logic              rst,
  input  lgr_pkg::lgr_ctrl_t ctrl,
  input  logic              mask,
  input  logic              fresh,
  input  lgr_pkg::lgr_nbr_t left,
  input  lgr_pkg::lgr_nbr_t right,
  output lgr_pkg::lgr_nbr_t self_nbr,
  output logic              gen_mid,
  output logic              gen_last
);

  logic       upper, upper_next;
  logic       middle, middle_next;
  logic       u, m, f;
  logic       la, a, ra;
  logic [3:0] n_mid, n_last;

  assign u = upper & mask;
  assign m = middle & mask;
  assign f = fresh & mask;
  assign self_nbr = '{upper: u, middle: m, fresh: f};

  // row above the final row is the middle row only when one is pending
  assign la = left.middle & ctrl.have_middle;
  assign a  = m & ctrl.have_middle;
  assign ra = right.middle & ctrl.have_middle;

  always_comb begin
    n_mid = 4'(left.upper) + 4'(u) + 4'(right.upper)
          + 4'(left.middle) + 4'(right.middle)
          + 4'(left.fresh) + 4'(f) + 4'(right.fresh);
    n_last = 4'(la) + 4'(a) + 4'(ra) + 4'(left.fresh) + 4'(right.fresh);
    gen_mid  = mask & ((n_mid == 4'd3) | (m & (n_mid == 4'd2)));
    gen_last = mask & ((n_last == 4'd3) | (f & (n_last == 4'd2)));
  end

  always_comb begin
    upper_next  = upper;
    middle_next = middle;
    if (ctrl.load) begin
      if (ctrl.last) begin
        upper_next  = 1'b0;
        middle_next = 1'b0;
      end else if (ctrl.have_middle) begin
        upper_next  = middle;
        middle_next = f;
      end else begin
        upper_next  = 1'b0;
        middle_next = f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper  <= 1'b0;
      middle <= 1'b0;
    end else begin
      upper  <= upper_next;
      middle <= middle_next;
    end
  end

endmodule

/* hdl/lgr_out_fifo.sv */
// result queue: takes up to two beats per cycle, hands out one when gen_ready is high
// depends on lgr_pkg
module lgr_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  lgr_pkg::lgr_push_t push,
  input  lgr_pkg::lgr_gen_t  first_beat,
  input  lgr_pkg::lgr_gen_t  second_beat,
  output logic               room_two,
  output logic               gen_valid,
  input  logic               gen_ready,
  output lgr_pkg::lgr_gen_t  gen_beat
);

  lgr_pkg::lgr_gen_t                 mem [lgr_pkg::FIFO_DEPTH];
  logic [lgr_pkg::FIFO_PTR_W-1:0]    wptr, rptr, wptr_plus;
  logic [lgr_pkg::FIFO_CNT_W-1:0]    count, n_push;
  logic                              pop;

  assign pop       = gen_valid & gen_ready;
  assign n_push    = lgr_pkg::FIFO_CNT_W'(push.first) + lgr_pkg::FIFO_CNT_W'(push.second);
  assign wptr_plus = wptr + lgr_pkg::FIFO_PTR_W'(1);
  assign room_two  = count <= lgr_pkg::FIFO_CNT_W'(lgr_pkg::FIFO_DEPTH - 2);
  assign gen_valid = count != '0;
  assign gen_beat  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + lgr_pkg::FIFO_PTR_W'(n_push);
      rptr  <= rptr + lgr_pkg::FIFO_PTR_W'(pop);
      count <= count + n_push - lgr_pkg::FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wptr] <= first_beat;
      if (push.second) begin
        mem[wptr_plus] <= second_beat;
      end
    end else if (push.second) begin
      mem[wptr] <= second_beat;
    end
  end

endmodule
